// ----- design/amf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package amf_pkg;

  localparam int PixelBits = 8;
  localparam int MaxWindow = 7;
  localparam int Cols      = 7;
  localparam int Centre    = 3;
  localparam int NumPix    = Cols * Cols;
  localparam int MaxRadius = (MaxWindow / 2 < 1) ? 1 : ((MaxWindow / 2 > 3) ? 3 : MaxWindow / 2);
  localparam int RankBits  = $clog2(NumPix + 1);
  localparam int BitIdxW   = $clog2(PixelBits);

  typedef logic [PixelBits-1:0] pix_t;
  typedef logic [1:0]           radius_t;
  typedef logic [RankBits-1:0]  rank_t;
  typedef logic [NumPix-1:0]    pmask_t;

  typedef struct packed {
    logic                shift;
    logic                init_start;
    logic                init_next;
    logic                step;
    logic                load_out;
    logic [BitIdxW-1:0]  bit_idx;
  } amf_cmd_t;

  typedef struct packed {
    logic row_full;
    logic decided;
  } amf_stat_t;

  // rank of the median inside a (2r+1)^2 window
  function automatic rank_t median_rank(radius_t r);
    int side;
    side = 2 * int'(r) + 1;
    return rank_t'((side * side) / 2);
  endfunction

  // element i = column*Cols + row
  function automatic pmask_t window_mask(radius_t r);
    pmask_t m;
    int     dc;
    int     dr;
    for (int i = 0; i < NumPix; i++) begin
      dc   = i / Cols - Centre;
      dr   = i % Cols - Centre;
      m[i] = (dc <= int'(r)) && (dc >= -int'(r)) && (dr <= int'(r)) && (dr >= -int'(r));
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- design/amf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface amf_in_if;
  import amf_pkg::*;
  logic valid;
  logic ready;
  pix_t pix_row0;
  pix_t pix_row1;
  pix_t pix_row2;
  pix_t pix_row3;
  pix_t pix_row4;
  pix_t pix_row5;
  pix_t pix_row6;
  logic row_start;
  modport source (output valid, pix_row0, pix_row1, pix_row2, pix_row3, pix_row4,
                  pix_row5, pix_row6, row_start, input ready);
  modport sink (input valid, pix_row0, pix_row1, pix_row2, pix_row3, pix_row4,
                pix_row5, pix_row6, row_start, output ready);
endinterface

interface amf_out_if;
  import amf_pkg::*;
  logic    valid;
  logic    ready;
  pix_t    filtered_pixel;
  radius_t used_radius;
  modport source (output valid, filtered_pixel, used_radius, input ready);
  modport sink (input valid, filtered_pixel, used_radius, output ready);
endinterface
`default_nettype wire

// ----- design/amf_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module amf_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  amf_pkg::amf_cmd_t   cmd_i,
  output amf_pkg::amf_stat_t  stat_o,
  input  amf_pkg::pix_t       col_i [amf_pkg::Cols],
  input  wire                 row_start_i,
  input  amf_pkg::radius_t    start_radius_i,
  output amf_pkg::pix_t       out_pixel_o,
  output amf_pkg::radius_t    out_radius_o
);
  import amf_pkg::*;

  pix_t    win_q [Cols][Cols];
  logic [2:0] cnt_q, cnt_d, cnt_base;
  pmask_t  med_alive_q, min_alive_q, max_alive_q;
  rank_t   k_q;
  pix_t    med_q, min_q, max_q;
  radius_t radius_q;
  pix_t    out_pix_q;
  radius_t out_rad_q;

  pmask_t  bitv, med_zero, min_zero, max_one;
  rank_t   cnt0;
  radius_t r_first, r_new;
  logic    spread_ok;
  pix_t    centre, result;

  assign cnt_base = row_start_i ? 3'd0 : cnt_q;
  assign cnt_d    = (cnt_base < 3'd7) ? cnt_base + 3'd1 : 3'd7;

  always_comb begin
    r_first = (start_radius_i == 2'd0) ? 2'd1 : start_radius_i;
    if (r_first > radius_t'(MaxRadius)) r_first = radius_t'(MaxRadius);
    r_new = cmd_i.init_start ? r_first : radius_q + 2'd1;
  end

  always_comb begin
    cnt0 = '0;
    for (int i = 0; i < NumPix; i++) begin
      bitv[i] = win_q[i / Cols][i % Cols][cmd_i.bit_idx];
    end
    med_zero = med_alive_q & ~bitv;
    min_zero = min_alive_q & ~bitv;
    max_one  = max_alive_q & bitv;
    for (int i = 0; i < NumPix; i++) begin
      cnt0 = cnt0 + rank_t'(med_zero[i]);
    end
  end

  assign centre    = win_q[Centre][Centre];
  assign spread_ok = (min_q < med_q) && (med_q < max_q);
  assign result    = (spread_ok && (min_q < centre) && (centre < max_q)) ? centre : med_q;

  assign stat_o.row_full = (cnt_d == 3'd7);
  assign stat_o.decided  = spread_ok || (radius_q == radius_t'(MaxRadius));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (cmd_i.shift) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int c = 0; c < Cols - 1; c++) win_q[c] <= win_q[c + 1];
      win_q[Cols - 1] <= col_i;
    end
    if (cmd_i.init_start || cmd_i.init_next) begin
      radius_q    <= r_new;
      med_alive_q <= window_mask(r_new);
      min_alive_q <= window_mask(r_new);
      max_alive_q <= window_mask(r_new);
      k_q         <= median_rank(r_new);
    end else if (cmd_i.step) begin
      // one bit of median, minimum and maximum per cycle, MSB first
      if (k_q < cnt0) begin
        med_q[cmd_i.bit_idx] <= 1'b0;
        med_alive_q          <= med_zero;
      end else begin
        med_q[cmd_i.bit_idx] <= 1'b1;
        med_alive_q          <= med_alive_q & bitv;
        k_q                  <= k_q - cnt0;
      end
      if (|min_zero) begin
        min_q[cmd_i.bit_idx] <= 1'b0;
        min_alive_q          <= min_zero;
      end else begin
        min_q[cmd_i.bit_idx] <= 1'b1;
      end
      if (|max_one) begin
        max_q[cmd_i.bit_idx] <= 1'b1;
        max_alive_q          <= max_one;
      end else begin
        max_q[cmd_i.bit_idx] <= 1'b0;
      end
    end
    if (cmd_i.load_out) begin
      out_pix_q <= result;
      out_rad_q <= radius_q;
    end
  end

  assign out_pixel_o  = out_pix_q;
  assign out_radius_o = out_rad_q;

endmodule
`default_nettype wire

// ----- design/amf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module amf_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  amf_pkg::amf_stat_t  stat_i,
  output amf_pkg::amf_cmd_t   cmd_o
);
  import amf_pkg::*;

  typedef enum logic [1:0] {Idle, Scan, Eval, Hold} state_e;

  state_e               state_q;
  logic [BitIdxW-1:0]   bit_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 in_acc;

  assign in_ready_o  = (state_q == Idle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.bit_idx    = bit_q;
    cmd_o.shift      = in_acc;
    cmd_o.init_start = in_acc && stat_i.row_full;
    cmd_o.step       = (state_q == Scan);
    cmd_o.init_next  = (state_q == Eval) && !stat_i.decided;
    cmd_o.load_out   = ((state_q == Eval && stat_i.decided) || state_q == Hold) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        Idle: begin
          if (cmd_o.init_start) begin
            state_q <= Scan;
            bit_q   <= BitIdxW'(PixelBits - 1);
          end
        end
        Scan: begin
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) state_q <= Eval;
        end
        Eval: begin
          if (!stat_i.decided) begin
            state_q <= Scan;
            bit_q   <= BitIdxW'(PixelBits - 1);
          end else if (out_free) begin
            state_q <= Idle;
          end else begin
            state_q <= Hold;
          end
        end
        Hold: begin
          if (out_free) state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/adaptive_median_filter.sv -----
// Flow: a column that completes a 7-column window is filtered in Scan and Eval; the pixel
// beat is raised once a window size decides and the output is free, and each larger window adds another Scan and Eval.
// Busy: no column is taken until it is done; each window size takes 8 bit steps
// of the shared rank/min/max unit plus one Eval decision; other columns are taken while Idle.
// Reset: window count cleared, start_radius set to 1, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_median_filter (
  input  wire          clk_i,
  input  wire          rst_ni,
  amf_in_if.sink       pix_in,
  amf_out_if.source    res_out,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire [2:0]    paddr,
  input  wire [31:0]   pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import amf_pkg::*;

  radius_t   start_radius_q;
  amf_cmd_t  cmd;
  amf_stat_t stat;
  pix_t      col [Cols];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, start_radius_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_radius_q <= 2'd1;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      start_radius_q <= pwdata[1:0];
    end
  end

  assign col[0] = pix_in.pix_row0;
  assign col[1] = pix_in.pix_row1;
  assign col[2] = pix_in.pix_row2;
  assign col[3] = pix_in.pix_row3;
  assign col[4] = pix_in.pix_row4;
  assign col[5] = pix_in.pix_row5;
  assign col[6] = pix_in.pix_row6;

  amf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .out_valid_o (res_out.valid),
    .out_ready_i (res_out.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  amf_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .col_i          (col),
    .row_start_i    (pix_in.row_start),
    .start_radius_i (start_radius_q),
    .out_pixel_o    (res_out.filtered_pixel),
    .out_radius_o   (res_out.used_radius)
  );

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_in.valid && pix_in.ready) |=> !$rose(res_out.valid))
    else $error("result appeared right after a column beat");

  a_radius_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid |-> (res_out.used_radius != 2'd0 &&
                       res_out.used_radius <= radius_t'(MaxRadius)))
    else $error("used_radius out of range");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_in.valid && pix_in.ready && stat.row_full) |=> !pix_in.ready)
    else $error("column accepted while a window is being filtered");

endmodule
`default_nettype wire

// ----- tb/tb_adaptive_median_filter.sv -----
`timescale 1ns / 1ps
module tb_adaptive_median_filter;
  import amf_pkg::*;

  typedef struct {
    pix_t    pix;
    radius_t radius;
  } amf_result_t;

  class median_scoreboard;
    logic [55:0] cols[7];
    int unsigned seen;
    radius_t     start_r;
    amf_result_t pending[$];
    int          mismatches;

    function void clear();
      foreach (cols[i]) cols[i] = '0;
      seen = 0;
      start_r = 2'd1;
      pending.delete();
      mismatches = 0;
    endfunction

    function pix_t pixel(int row, int col);
      return cols[col][row*8 +: 8];
    endfunction

    // shift the column in and, on a full window, predict the filtered pixel
    function void note_column(logic [55:0] col, logic rs);
      int          r;
      int          n;
      int          k;
      pix_t        vals[49];
      pix_t        v;
      pix_t        zmin;
      pix_t        zmid;
      pix_t        zmax;
      pix_t        ctr;
      amf_result_t res;
      if (rs) seen = 0;
      for (int i = 0; i < 6; i++) cols[i] = cols[i+1];
      cols[6] = col;
      if (seen < 7) seen++;
      if (seen < 7) return;
      r = (start_r == 0) ? 1 : int'(start_r);
      if (r > MaxRadius) r = MaxRadius;
      ctr = pixel(Centre, Centre);
      forever begin
        n = 0;
        for (int a = Centre - r; a <= Centre + r; a++)
          for (int b = Centre - r; b <= Centre + r; b++) begin
            v = pixel(a, b);
            k = n;
            while (k > 0 && vals[k-1] > v) begin
              vals[k] = vals[k-1];
              k--;
            end
            vals[k] = v;
            n++;
          end
        zmin = vals[0];
        zmax = vals[n-1];
        zmid = vals[n/2];
        if (zmin < zmid && zmid < zmax) begin
          res.pix = (zmin < ctr && ctr < zmax) ? ctr : zmid;
          break;
        end
        if (r >= MaxRadius) begin
          res.pix = zmid;
          break;
        end
        r++;
      end
      res.radius = radius_t'(r);
      pending = {pending, res};
    endfunction

    function void check_pixel(pix_t p, radius_t rad);
      amf_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: pixel %0d radius %0d", p, rad);
        return;
      end
      e = pending.pop_front();
      if (e.pix !== p || e.radius !== rad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected pixel %0d radius %0d, got pixel %0d radius %0d",
                   e.pix, e.radius, p, rad);
      end
    endfunction
  endclass

  localparam int StallLimit = 20000;
  localparam logic [2:0] AddrStartRadius = 3'd0;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        quiet;
  int          idle_cycles;

  amf_in_if  pix_in ();
  amf_out_if res_out ();

  median_scoreboard sb;

  adaptive_median_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_in.sink),
    .res_out (res_out.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // check every accepted result beat; watchdog on idle cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_out.valid && res_out.ready)
        sb.check_pixel(res_out.filtered_pixel, res_out.used_radius);
      if ((pix_in.valid && pix_in.ready) || (res_out.valid && res_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // random backpressure in bursts
  initial begin
    int burst;
    res_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 18);
        res_out.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end else begin
        res_out.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic write_radius(logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= AddrStartRadius;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.start_r = radius_t'(value[1:0]);
  endtask

  // valid stays high after a beat until the next column or an idle gap replaces it
  task automatic send_column(logic [55:0] col, logic rs);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    pix_in.valid     <= 1'b1;
    pix_in.pix_row0  <= col[7:0];
    pix_in.pix_row1  <= col[15:8];
    pix_in.pix_row2  <= col[23:16];
    pix_in.pix_row3  <= col[31:24];
    pix_in.pix_row4  <= col[39:32];
    pix_in.pix_row5  <= col[47:40];
    pix_in.pix_row6  <= col[55:48];
    pix_in.row_start <= rs;
    do @(posedge clk_i); while (!pix_in.ready);
    sb.note_column(col, rs);
  endtask

  // drop valid, wait for all results, then let any unfinished window drain
  task automatic drain();
    pix_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [55:0] rand_column(int style);
    logic [55:0] c;
    for (int i = 0; i < 7; i++)
      case (style)
        0: c[i*8 +: 8] = 8'($urandom);
        1: c[i*8 +: 8] = 8'($urandom_range(100, 104));
        2: c[i*8 +: 8] = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1)) ? 8'hff : 8'h00)
                                                    : 8'($urandom_range(90, 110));
        default: c[i*8 +: 8] = 8'd128;
      endcase
    return c;
  endfunction

  task automatic send_row(int len, int style);
    for (int i = 0; i < len; i++) send_column(rand_column(style), i == 0);
  endtask

  initial begin
    logic [31:0] radii[5];
    radii = '{32'd1, 32'd3, 32'd0, 32'd2, 32'd1};
    sb = new();
    sb.clear();
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 1'b0;
    idle_cycles = 0;
    pix_in.valid = 1'b0;
    pix_in.pix_row0 = '0;
    pix_in.pix_row1 = '0;
    pix_in.pix_row2 = '0;
    pix_in.pix_row3 = '0;
    pix_in.pix_row4 = '0;
    pix_in.pix_row5 = '0;
    pix_in.pix_row6 = '0;
    pix_in.row_start = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: flat, extremes, impulse at centre, row restart
    for (int i = 0; i < 8; i++) send_column(rand_column(3), i == 0);
    send_column(56'hffffffffffffff, 1'b0);
    send_column(56'h00000000000000, 1'b0);
    send_column(56'h000000ff000000, 1'b0);
    send_column(56'hff00ff00ff00ff, 1'b0);
    send_column(56'h00ff00ff00ff00, 1'b0);
    send_column(56'h01020304050607, 1'b1);
    for (int i = 0; i < 7; i++) send_column(rand_column(0), 1'b0);
    drain();

    foreach (radii[p]) begin
      write_radius(radii[p]);
      for (int n = 0; n < 200; ) begin
        int len;
        len = $urandom_range(1, 14);
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 6);
        if (p == 4) quiet = 1'b1;
        send_row(len, $urandom_range(0, 3));
        n += len;
      end
      drain();
    end
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
